### hw/rtl/mbrp_pkg.sv
// Shared types, codes and helpers for the Modbus request parser.
`default_nettype none

package mbrp_pkg;

   // Result kinds.
   typedef enum logic [1:0] {
      KindHeader = 2'd0,
      KindData   = 2'd1,
      KindError  = 2'd2
   } kind_type;

   // Function classes; each known class selects a header layout (ClassMask shares that of ClassSingle).
   typedef enum logic [2:0] {
      ClassUnknown = 3'd0,
      ClassRead    = 3'd1,
      ClassSingle  = 3'd2,
      ClassMask    = 3'd3,
      ClassMulti   = 3'd4,
      ClassWrRd    = 3'd5
   } class_type;

   // Function codes.
   localparam logic [7:0] FnReadCoils      = 8'd1;
   localparam logic [7:0] FnReadDiscrete   = 8'd2;
   localparam logic [7:0] FnReadHolding    = 8'd3;
   localparam logic [7:0] FnReadInput      = 8'd4;
   localparam logic [7:0] FnWriteCoil      = 8'd5;
   localparam logic [7:0] FnWriteRegister  = 8'd6;
   localparam logic [7:0] FnWriteCoils     = 8'd15;
   localparam logic [7:0] FnWriteRegisters = 8'd16;
   localparam logic [7:0] FnMaskWrite      = 8'd22;
   localparam logic [7:0] FnWriteRead      = 8'd23;

   // Exception responses carry the top bit of the function code.
   localparam logic [7:0] ExceptionMask = 8'h80;

   // Last header byte position for each class; ClassMask also uses EndSingle.
   localparam logic [7:0] EndRead   = 8'd5;
   localparam logic [7:0] EndSingle = 8'd3;
   localparam logic [7:0] EndMulti  = 8'd6;
   localparam logic [7:0] EndWrRd   = 8'd10;

   // First write field position.
   localparam logic [7:0] WriteBaseWrRd  = 8'd6;
   localparam logic [7:0] WriteBasePlain = 8'd2;

   // Fixed data lengths.
   localparam logic [7:0] LenSingle = 8'd2;
   localparam logic [7:0] LenMask   = 8'd4;

   // Value of a field the function does not use.
   localparam logic [15:0] FieldUnused = 16'hFFFF;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  slave_id;
      logic [7:0]  function_code;
      logic [15:0] read_start;
      logic [15:0] read_count;
      logic [15:0] write_start;
      logic [15:0] write_count;
      logic [7:0]  byte_count;
      logic [7:0]  data_byte;
      logic [7:0]  data_index;
      logic        last;
   } rsp_type;

   // A result on its way from the parser to the output buffer.
   typedef struct packed {
      logic    valid;
      rsp_type payload;
   } result_type;

   // Sorts a function code into its header layout.
   function automatic class_type classify(input logic [7:0] code);
      class_type cls;
      if ((code & ExceptionMask) != 8'd0) begin
         cls = ClassUnknown;
      end else begin
         unique case (code) inside
            FnReadCoils, FnReadDiscrete, FnReadHolding, FnReadInput: begin
               cls = ClassRead;
            end
            FnWriteCoil, FnWriteRegister: begin
               cls = ClassSingle;
            end
            FnMaskWrite: begin
               cls = ClassMask;
            end
            FnWriteCoils, FnWriteRegisters: begin
               cls = ClassMulti;
            end
            FnWriteRead: begin
               cls = ClassWrRd;
            end
            default: begin
               cls = ClassUnknown;
            end
         endcase
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/mbrp_req_if.sv
// Valid/ready channel that carries received request bytes.
`default_nettype none

interface mbrp_req_if;
   logic             valid;
   logic             ready;
   mbrp_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/mbrp_rsp_if.sv
// Valid/ready channel that carries parser results.
`default_nettype none

interface mbrp_rsp_if;
   logic             valid;
   logic             ready;
   mbrp_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/modbus_request_parser.sv
// Modbus request parser top level: frame parser followed by a buffered result channel.
//
// req_chan takes one received byte per item, with frame_start set on the
// first byte of each request frame (the unit address). rsp_chan gives at
// most one result per byte: a header result once the function's header
// bytes are in, one data result per payload byte with its index and a last
// flag, or an error result for an exception or unknown function code.
// A byte is taken in every cycle while the skid stage is empty; its result
// is registered in the output register, or in the skid stage when the
// output register is full and not taken. The byte position and header
// fields sit in one register bank, and one pass of logic over it settles
// each byte. After reset the parser ignores bytes until a frame start, and
// both the result register and the skid stage are empty. When the receiver
// stalls, one further result is held in the skid stage; req_chan.ready then
// drops until the output register frees up again, and no result is dropped.
`default_nettype none

module modbus_request_parser (
   input  wire logic  clock,
   input  wire logic  reset,
   mbrp_req_if.sink   req_chan,
   mbrp_rsp_if.source rsp_chan
);

   mbrp_pkg::result_type result;
   logic                 accept;
   logic                 in_ready;

   assign accept         = req_chan.valid && in_ready;
   assign req_chan.ready = in_ready;

   // Byte-by-byte frame parser.
   mbrp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_chan.payload),
      .result (result)
   );

   // Result register and skid stage.
   mbrp_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .in_ready    (in_ready),
      .out_valid   (rsp_chan.valid),
      .out_payload (rsp_chan.payload),
      .out_ready   (rsp_chan.ready)
   );

endmodule

`default_nettype wire

### hw/rtl/mbrp_parser.sv
// Frame state and header capture: turns one accepted byte into at most one result.
`default_nettype none

module mbrp_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire mbrp_pkg::req_type      item,
   output mbrp_pkg::result_type        result
);

   typedef enum logic [1:0] {
      PhIdle   = 2'd0,
      PhHeader = 2'd1,
      PhData   = 2'd2,
      PhDone   = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  unit_ff, unit_in;
   logic [7:0]  func_ff, func_in;
   logic [15:0] rd_start_ff, rd_start_in;
   logic [15:0] rd_count_ff, rd_count_in;
   logic [15:0] wr_start_ff, wr_start_in;
   logic [15:0] wr_count_ff, wr_count_in;
   logic [7:0]  len_ff, len_in;

   mbrp_pkg::class_type cls;
   logic [7:0]          end_pos;
   logic [7:0]          wbase;
   logic [7:0]          rd_off;
   logic [7:0]          wr_off;
   logic [8:0]          next_index;
   logic                res_valid;
   mbrp_pkg::kind_type  res_kind;
   logic [7:0]          res_bc;
   logic [7:0]          res_db;
   logic [7:0]          res_idx;
   logic                res_last;

   // Header layout of the held function code.
   always_comb begin
      cls = mbrp_pkg::classify(func_ff);
      case (cls)
         mbrp_pkg::ClassRead:   end_pos = mbrp_pkg::EndRead;
         mbrp_pkg::ClassSingle: end_pos = mbrp_pkg::EndSingle;
         mbrp_pkg::ClassMask:   end_pos = mbrp_pkg::EndSingle;
         mbrp_pkg::ClassMulti:  end_pos = mbrp_pkg::EndMulti;
         default:               end_pos = mbrp_pkg::EndWrRd;
      endcase
      wbase      = (cls == mbrp_pkg::ClassWrRd) ? mbrp_pkg::WriteBaseWrRd
                                                : mbrp_pkg::WriteBasePlain;
      rd_off     = pos_ff - mbrp_pkg::WriteBasePlain;
      wr_off     = pos_ff - wbase;
      next_index = {1'b0, pos_ff} + 9'd1;
   end

   // Next frame state and the result of this item.
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      unit_in     = unit_ff;
      func_in     = func_ff;
      rd_start_in = rd_start_ff;
      rd_count_in = rd_count_ff;
      wr_start_in = wr_start_ff;
      wr_count_in = wr_count_ff;
      len_in      = len_ff;
      res_valid   = 1'b0;
      res_kind    = mbrp_pkg::KindHeader;
      res_bc      = 8'd0;
      res_db      = 8'd0;
      res_idx     = 8'd0;
      res_last    = 1'b0;
      if (accept) begin
         if (item.frame_start) begin
            // A frame start always restarts the parser.
            phase_in    = PhHeader;
            pos_in      = 8'd1;
            unit_in     = item.rx_byte;
            func_in     = 8'd0;
            rd_start_in = mbrp_pkg::FieldUnused;
            rd_count_in = mbrp_pkg::FieldUnused;
            wr_start_in = mbrp_pkg::FieldUnused;
            wr_count_in = mbrp_pkg::FieldUnused;
            len_in      = 8'd0;
         end else begin
            unique case (phase_ff)
               PhData: begin
                  res_valid = 1'b1;
                  res_kind  = mbrp_pkg::KindData;
                  res_bc    = len_ff;
                  res_db    = item.rx_byte;
                  res_idx   = pos_ff;
                  res_last  = (next_index >= {1'b0, len_ff});
                  if (res_last) begin
                     phase_in = PhDone;
                  end else begin
                     pos_in = next_index[7:0];
                  end
               end
               PhHeader: begin
                  if (pos_ff <= 8'd1) begin
                     // Function code byte.
                     func_in = item.rx_byte;
                     if (mbrp_pkg::classify(item.rx_byte) == mbrp_pkg::ClassUnknown) begin
                        phase_in  = PhDone;
                        res_valid = 1'b1;
                        res_kind  = mbrp_pkg::KindError;
                        res_last  = 1'b1;
                     end else begin
                        pos_in = 8'd2;
                     end
                  end else begin
                     // Capture the header field that this position belongs to.
                     if ((cls == mbrp_pkg::ClassRead || cls == mbrp_pkg::ClassWrRd)
                         && pos_ff >= 8'd2 && pos_ff <= 8'd5) begin
                        case (rd_off[1:0])
                           2'd0:    rd_start_in[15:8] = item.rx_byte;
                           2'd1:    rd_start_in[7:0]  = item.rx_byte;
                           2'd2:    rd_count_in[15:8] = item.rx_byte;
                           default: rd_count_in[7:0]  = item.rx_byte;
                        endcase
                     end else if (cls != mbrp_pkg::ClassRead && pos_ff >= wbase
                                  && pos_ff < wbase + 8'd4) begin
                        case (wr_off[1:0])
                           2'd0:    wr_start_in[15:8] = item.rx_byte;
                           2'd1:    wr_start_in[7:0]  = item.rx_byte;
                           2'd2:    wr_count_in[15:8] = item.rx_byte;
                           default: wr_count_in[7:0]  = item.rx_byte;
                        endcase
                     end else if (pos_ff == end_pos && (cls == mbrp_pkg::ClassMulti
                                  || cls == mbrp_pkg::ClassWrRd)) begin
                        len_in = item.rx_byte;
                     end

                     if (pos_ff < end_pos) begin
                        pos_in = pos_ff + 8'd1;
                     end else begin
                        // Header complete: settle the fixed lengths and report it.
                        if (cls == mbrp_pkg::ClassSingle) begin
                           wr_count_in = 16'd1;
                           len_in      = mbrp_pkg::LenSingle;
                        end else if (cls == mbrp_pkg::ClassMask) begin
                           wr_count_in = 16'd1;
                           len_in      = mbrp_pkg::LenMask;
                        end else if (cls == mbrp_pkg::ClassRead) begin
                           len_in = 8'd0;
                        end
                        res_valid = 1'b1;
                        res_kind  = mbrp_pkg::KindHeader;
                        res_bc    = len_in;
                        res_last  = (len_in == 8'd0);
                        phase_in  = res_last ? PhDone : PhData;
                        pos_in    = 8'd0;
                     end
                  end
               end
               default: begin
                  // Idle or frame ended: the byte is ignored.
               end
            endcase
         end
      end
   end

   // The result always reports the header fields as they stand after this item.
   always_comb begin
      result.valid                 = res_valid;
      result.payload.kind          = res_kind;
      result.payload.slave_id      = unit_in;
      result.payload.function_code = func_in;
      result.payload.read_start    = rd_start_in;
      result.payload.read_count    = rd_count_in;
      result.payload.write_start   = wr_start_in;
      result.payload.write_count   = wr_count_in;
      result.payload.byte_count    = res_bc;
      result.payload.data_byte     = res_db;
      result.payload.data_index    = res_idx;
      result.payload.last          = res_last;
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhIdle;
         pos_ff      <= 8'd0;
         unit_ff     <= 8'd0;
         func_ff     <= 8'd0;
         rd_start_ff <= mbrp_pkg::FieldUnused;
         rd_count_ff <= mbrp_pkg::FieldUnused;
         wr_start_ff <= mbrp_pkg::FieldUnused;
         wr_count_ff <= mbrp_pkg::FieldUnused;
         len_ff      <= 8'd0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         unit_ff     <= unit_in;
         func_ff     <= func_in;
         rd_start_ff <= rd_start_in;
         rd_count_ff <= rd_count_in;
         wr_start_ff <= wr_start_in;
         wr_count_ff <= wr_count_in;
         len_ff      <= len_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/mbrp_out_buf.sv
// Result register with a skid stage, so input keeps flowing while a result waits.
`default_nettype none

module mbrp_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mbrp_pkg::result_type result,
   output logic                      in_ready,
   output logic                      out_valid,
   output mbrp_pkg::rsp_type         out_payload,
   input  wire logic                 out_ready
);

   logic              out_valid_ff, out_valid_in;
   mbrp_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   mbrp_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              out_take;

   // Refill the output register from the skid stage first, then from the parser.
   always_comb begin
      out_take      = out_valid_ff && out_ready;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result.valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = result.payload;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result.payload;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   assign in_ready    = !skid_valid_ff;
   assign out_valid   = out_valid_ff;
   assign out_payload = out_data_ff;

   // Buffer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire
